FILE: design/four_pin_position_calibrator_macros.svh
// Assertion macros for the four-pin position calibrator.
`ifndef FOUR_PIN_POSITION_CALIBRATOR_MACROS_SVH
`define FOUR_PIN_POSITION_CALIBRATOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: design/fpc_pkg.sv
// Package with shared types and constants of the four-pin position calibrator.
`timescale 1ns / 1ps
package fpc_pkg;
	localparam int PinLow = 250;
	localparam int RawLimit = 4096;
	localparam int PosScale = 25 * 1024;
	localparam int QuoWidth = 17;
	localparam int DivWidth = 40;

	typedef enum logic [2:0] {
		REG_PIN_OFFSETS = 3'd0,
		REG_ENERGY_GAIN = 3'd1,
		REG_ENERGY_OFFSET = 3'd2,
		REG_TIME_GAIN = 3'd3,
		REG_TIME_OFFSET = 3'd4,
		REG_X_CORRECTION = 3'd5,
		REG_Y_CORRECTION = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [47:0] pin_offsets;
		logic [15:0] energy_gain;
		logic signed [15:0] energy_offset;
		logic [15:0] time_gain;
		logic signed [15:0] time_offset;
		logic [31:0] x_correction;
		logic [31:0] y_correction;
	} cfg_t;

	typedef struct packed {
		logic si_fired;
		logic signed [23:0] energy_cal;
		logic signed [23:0] time_calibrated;
		logic calibrated_in_window;
		logic [2:0] pin_multiplicity;
		logic [5:0] signal_mask;
		logic position_valid;
	} side_t;

	typedef struct packed {
		logic si_fired;
		logic signed [23:0] energy_cal;
		logic signed [23:0] time_calibrated;
		logic calibrated_in_window;
		logic [2:0] pin_multiplicity;
		logic [5:0] signal_mask;
		logic position_valid;
		logic signed [15:0] x_position;
		logic signed [15:0] y_position;
		logic signed [15:0] x_corrected;
		logic signed [15:0] y_corrected;
	} result_t;

	// Saturate a wide signed value to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767) r = 16'sh7fff;
		else if (v < -48'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction
endpackage

FILE: design/fpc_if.sv
// Valid/ready channel interface carrying one data payload.
`timescale 1ns / 1ps
interface fpc_if #(parameter int W = 1) ();
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/fpc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, signed wrapper.
`timescale 1ns / 1ps
module fpc_divider #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 20,
	parameter int QUO_W = 17,
	parameter int TAG_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [NUM_W-1:0] num,
	input logic signed [DEN_W-1:0] den,
	input logic [TAG_W-1:0] tag_in,
	output logic out_valid,
	output logic signed [QUO_W:0] quo,
	output logic [TAG_W-1:0] tag_out
);
	// Magnitudes; quotient magnitude saturates at all ones of QUO_W bits.
	localparam int STAGES = QUO_W;
	logic [NUM_W-1:0] rem_s [STAGES+1];
	logic [DEN_W-1:0] dv_s [STAGES+1];
	logic [QUO_W-1:0] q_s [STAGES+1];
	logic ovf_s [STAGES+1];
	logic neg_s [STAGES+1];
	logic vld_s [STAGES+1];
	logic [TAG_W-1:0] tag_s [STAGES+1];

	logic [NUM_W-1:0] nmag;
	logic [DEN_W-1:0] dmag;
	assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign dmag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

	always_comb begin
		rem_s[0] = nmag;
		dv_s[0] = dmag;
		q_s[0] = '0;
		ovf_s[0] = ((nmag >> QUO_W) >= NUM_W'(dmag));
		neg_s[0] = num[NUM_W-1] ^ den[DEN_W-1];
		vld_s[0] = in_valid;
		tag_s[0] = tag_in;
	end

	// One quotient bit per registered stage, most significant first.
	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		localparam int SH = STAGES - 1 - g;
		logic [NUM_W-1:0] rem_r;
		logic [DEN_W-1:0] dv_r;
		logic [QUO_W-1:0] q_r;
		logic ovf_r, neg_r, vld_r;
		logic [TAG_W-1:0] tag_r;
		logic [NUM_W+QUO_W-1:0] dsh;
		logic fit;
		assign dsh = (NUM_W+QUO_W)'(dv_s[g]) << SH;
		assign fit = (NUM_W+QUO_W)'(rem_s[g]) >= dsh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_r <= 1'b0;
			else if (en) vld_r <= vld_s[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_r <= fit ? NUM_W'((NUM_W+QUO_W)'(rem_s[g]) - dsh) : rem_s[g];
				q_r <= q_s[g] | (fit ? (QUO_W'(1) << SH) : '0);
				dv_r <= dv_s[g];
				ovf_r <= ovf_s[g];
				neg_r <= neg_s[g];
				tag_r <= tag_s[g];
			end
		end
		assign rem_s[g+1] = rem_r;
		assign dv_s[g+1] = dv_r;
		assign q_s[g+1] = q_r;
		assign ovf_s[g+1] = ovf_r;
		assign neg_s[g+1] = neg_r;
		assign vld_s[g+1] = vld_r;
		assign tag_s[g+1] = tag_r;
	end

	logic [QUO_W-1:0] qm;
	assign qm = ovf_s[STAGES] ? '1 : q_s[STAGES];
	assign quo = neg_s[STAGES] ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
	assign out_valid = vld_s[STAGES];
	assign tag_out = tag_s[STAGES];
endmodule

FILE: design/fpc_front.sv
// Front stages: windows, linear calibration, pin offsets and position numerators.
`timescale 1ns / 1ps
module fpc_front #(
	parameter int RAW_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [15:0] energy_raw,
	input logic [15:0] time_raw,
	input logic [15:0] pin_a_raw,
	input logic [15:0] pin_b_raw,
	input logic [15:0] pin_c_raw,
	input logic [15:0] pin_d_raw,
	input fpc_pkg::cfg_t cfg,
	output logic out_valid,
	output fpc_pkg::side_t side,
	output logic signed [fpc_pkg::DivWidth-1:0] num_x,
	output logic signed [fpc_pkg::DivWidth-1:0] num_y,
	output logic signed [19:0] den
);
	import fpc_pkg::*;

	logic [RAW_WIDTH-1:0] e_r, t_r;
	logic [RAW_WIDTH-1:0] p_r [4];
	assign e_r = energy_raw[RAW_WIDTH-1:0];
	assign t_r = time_raw[RAW_WIDTH-1:0];
	assign p_r[0] = pin_a_raw[RAW_WIDTH-1:0];
	assign p_r[1] = pin_b_raw[RAW_WIDTH-1:0];
	assign p_r[2] = pin_c_raw[RAW_WIDTH-1:0];
	assign p_r[3] = pin_d_raw[RAW_WIDTH-1:0];

	// Stage 1: products, pin windows and offset subtraction.
	logic v_s1, fired_s1;
	logic [31:0] eprod_s1, tprod_s1;
	logic [3:0] pmask_s1;
	logic [1:0] nz_s1;
	logic signed [17:0] pc_s1 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fired_s1 <= (e_r != '0) && (32'(e_r) < 32'(RawLimit));
			eprod_s1 <= 32'(cfg.energy_gain) * 32'(e_r);
			tprod_s1 <= 32'(cfg.time_gain) * 32'(t_r);
			nz_s1 <= {t_r != '0, e_r != '0};
			for (int i = 0; i < 4; i++) begin
				pmask_s1[i] <= (32'(p_r[i]) > 32'(PinLow)) && (32'(p_r[i]) < 32'(RawLimit));
				pc_s1[i] <= $signed(18'(p_r[i])) - $signed(18'(cfg.pin_offsets[12*i +: 12]));
			end
		end
	end

	// Stage 2: calibrated values, pin sums.
	logic v_s2, fired_s2;
	logic signed [25:0] ecal_s2, tcal_s2;
	logic [3:0] pmask_s2;
	logic [1:0] nz_s2;
	logic signed [19:0] sum_s2, dx_s2, dy_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fired_s2 <= fired_s1;
			ecal_s2 <= $signed({2'b0, eprod_s1[31:8]}) + 26'(cfg.energy_offset);
			tcal_s2 <= $signed({2'b0, tprod_s1[31:8]}) + 26'(cfg.time_offset);
			pmask_s2 <= pmask_s1;
			nz_s2 <= nz_s1;
			sum_s2 <= 20'(pc_s1[0]) + 20'(pc_s1[1]) + 20'(pc_s1[2]) + 20'(pc_s1[3]);
			dx_s2 <= 20'(pc_s1[1]) + 20'(pc_s1[2]) - 20'(pc_s1[3]) - 20'(pc_s1[0]);
			dy_s2 <= 20'(pc_s1[3]) + 20'(pc_s1[2]) - 20'(pc_s1[0]) - 20'(pc_s1[1]);
		end
	end

	// Stage 3: saturation, window flags, scaled numerators.
	logic signed [23:0] ecs, tcs;
	assign ecs = (ecal_s2 > 26'sd8388607) ? 24'sh7fffff :
		(ecal_s2 < -26'sd8388608) ? 24'sh800000 : ecal_s2[23:0];
	assign tcs = (tcal_s2 > 26'sd8388607) ? 24'sh7fffff :
		(tcal_s2 < -26'sd8388608) ? 24'sh800000 : tcal_s2[23:0];
	logic allin;
	assign allin = &pmask_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side.si_fired <= fired_s2;
			side.energy_cal <= ecs;
			side.time_calibrated <= tcs;
			side.calibrated_in_window <= (ecs >= 24'sd16) && (ecs < 24'sd65536)
				&& (tcs >= 24'sd160) && (tcs < 24'sd60800);
			side.pin_multiplicity <= 3'(pmask_s2[0]) + 3'(pmask_s2[1])
				+ 3'(pmask_s2[2]) + 3'(pmask_s2[3]);
			side.signal_mask <= {nz_s2, pmask_s2};
			side.position_valid <= allin && (sum_s2 != '0);
			num_x <= DivWidth'(dx_s2) * DivWidth'($signed(PosScale));
			num_y <= DivWidth'(dy_s2) * DivWidth'($signed(PosScale));
			den <= (sum_s2 == '0) ? 20'sd1 : sum_s2;
		end
	end
endmodule

FILE: design/fpc_correct.sv
// Back stages: position saturation, linear correction and result register.
`timescale 1ns / 1ps
module fpc_correct (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input fpc_pkg::side_t side,
	input logic signed [fpc_pkg::QuoWidth:0] qx,
	input logic signed [fpc_pkg::QuoWidth:0] qy,
	input logic [31:0] x_correction,
	input logic [31:0] y_correction,
	output logic out_valid,
	output fpc_pkg::result_t res
);
	import fpc_pkg::*;

	// Stage A: saturate and multiply by the correction gains.
	logic v_a;
	side_t side_a;
	logic signed [15:0] x_a, y_a;
	logic signed [33:0] px_a, py_a;
	logic signed [15:0] xs, ys;
	assign xs = side.position_valid ? sat16(48'(qx)) : '0;
	assign ys = side.position_valid ? sat16(48'(qy)) : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_a <= 1'b0;
		else if (en) v_a <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_a <= side;
			x_a <= xs;
			y_a <= ys;
			px_a <= $signed({2'b0, x_correction[31:16]}) * 34'(xs);
			py_a <= $signed({2'b0, y_correction[31:16]}) * 34'(ys);
		end
	end

	// Stage B: floor shift, offset, saturate.
	logic signed [15:0] xc, yc;
	assign xc = sat16(48'(px_a >>> 12) + 48'($signed(x_correction[15:0])));
	assign yc = sat16(48'(py_a >>> 12) + 48'($signed(y_correction[15:0])));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_a;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res.si_fired <= side_a.si_fired;
			res.energy_cal <= side_a.energy_cal;
			res.time_calibrated <= side_a.time_calibrated;
			res.calibrated_in_window <= side_a.calibrated_in_window;
			res.pin_multiplicity <= side_a.pin_multiplicity;
			res.signal_mask <= side_a.signal_mask;
			res.position_valid <= side_a.position_valid;
			res.x_position <= x_a;
			res.y_position <= y_a;
			res.x_corrected <= side_a.position_valid ? xc : '0;
			res.y_corrected <= side_a.position_valid ? yc : '0;
		end
	end
endmodule

FILE: design/four_pin_position_calibrator.sv
// Pipeline from input request to result: 3 front, 17 divider, 2 correction stages and
// 1 output register; the quotient pipeline of one bit per stage sets depth.
// Throughput: one request per cycle while the output is not stalled.
// A stall on the output freezes the whole pipeline; output ready reaches input ready.
// Reset (arst_n low, asynchronous) clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
`include "four_pin_position_calibrator_macros.svh"
module four_pin_position_calibrator #(
	parameter int RAW_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	fpc_if.sink in_ch,
	fpc_if.source out_ch,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data
);
	import fpc_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pin_offsets <= '0;
			cfg_q.energy_gain <= 16'd4096;
			cfg_q.energy_offset <= '0;
			cfg_q.time_gain <= 16'd4096;
			cfg_q.time_offset <= '0;
			cfg_q.x_correction <= 32'h1000_0000;
			cfg_q.y_correction <= 32'h1000_0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIN_OFFSETS: cfg_q.pin_offsets <= cfg_data;
				REG_ENERGY_GAIN: cfg_q.energy_gain <= cfg_data[15:0];
				REG_ENERGY_OFFSET: cfg_q.energy_offset <= cfg_data[15:0];
				REG_TIME_GAIN: cfg_q.time_gain <= cfg_data[15:0];
				REG_TIME_OFFSET: cfg_q.time_offset <= cfg_data[15:0];
				REG_X_CORRECTION: cfg_q.x_correction <= cfg_data[31:0];
				REG_Y_CORRECTION: cfg_q.y_correction <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Pipeline advances whenever the output slot is free or being emptied.
	logic en;
	logic out_valid_q;
	assign en = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	logic f_valid, d_valid, c_valid;
	side_t f_side, d_side;
	logic signed [DivWidth-1:0] num_x, num_y;
	logic signed [19:0] den;
	logic signed [QuoWidth:0] qx, qy;
	result_t res;

	fpc_front #(.RAW_WIDTH(RAW_WIDTH)) u_front (
		.clk, .arst_n, .en,
		.in_valid(in_ch.valid && en),
		.energy_raw(in_ch.data[95:80]),
		.time_raw(in_ch.data[79:64]),
		.pin_a_raw(in_ch.data[63:48]),
		.pin_b_raw(in_ch.data[47:32]),
		.pin_c_raw(in_ch.data[31:16]),
		.pin_d_raw(in_ch.data[15:0]),
		.cfg(cfg_q),
		.out_valid(f_valid), .side(f_side),
		.num_x, .num_y, .den
	);

	fpc_divider #(.NUM_W(DivWidth), .DEN_W(20), .QUO_W(QuoWidth),
		.TAG_W($bits(side_t))) u_div_x (
		.clk, .arst_n, .en, .in_valid(f_valid), .num(num_x), .den,
		.tag_in(f_side), .out_valid(d_valid), .quo(qx), .tag_out(d_side)
	);

	logic unused_v;
	logic [$bits(side_t)-1:0] unused_tag;
	fpc_divider #(.NUM_W(DivWidth), .DEN_W(20), .QUO_W(QuoWidth), .TAG_W($bits(side_t)))
		u_div_y (
		.clk, .arst_n, .en, .in_valid(f_valid), .num(num_y), .den,
		.tag_in(f_side), .out_valid(unused_v), .quo(qy), .tag_out(unused_tag)
	);

	fpc_correct u_corr (
		.clk, .arst_n, .en, .in_valid(d_valid), .side(d_side), .qx, .qy,
		.x_correction(cfg_q.x_correction), .y_correction(cfg_q.y_correction),
		.out_valid(c_valid), .res
	);

	// Output register.
	result_t res_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= c_valid;
	end
	always_ff @(posedge clk) begin
		if (en) res_q <= res;
	end
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = res_q;

	`FPC_ASSERT_IMP(a_div_lanes, clk, arst_n, d_valid, unused_v && unused_tag == d_side)
	`FPC_ASSERT_IMP(a_pos_zero, clk, arst_n, out_valid_q && !res_q.position_valid,
		res_q.x_position == '0 && res_q.y_corrected == '0)
	`FPC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid_q && !out_ch.ready,
		out_valid_q && $stable(res_q))
	`FPC_ASSERT_IMP(a_mult, clk, arst_n, out_valid_q && res_q.position_valid,
		res_q.pin_multiplicity == 3'd4)
endmodule

FILE: dv/four_pin_position_calibrator_tb.sv
// Self-checking testbench of the four-pin position calibrator with a scoreboard class.
`timescale 1ns / 1ps
module four_pin_position_calibrator_tb;
	import fpc_pkg::*;

	typedef struct packed {
		logic [15:0] energy_raw;
		logic [15:0] time_raw;
		logic [15:0] pin_a_raw;
		logic [15:0] pin_b_raw;
		logic [15:0] pin_c_raw;
		logic [15:0] pin_d_raw;
	} event_t;

	localparam logic [2:0] RegUnused = 3'd7;
	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles = 40;
	localparam int LongHold = 400;

	// Keeps the register mirror, predicts each event and checks results in order.
	class position_scoreboard;
		bit [47:0] pin_off;
		bit [15:0] e_gain, t_gain;
		shortint e_off, t_off;
		bit [31:0] x_corr, y_corr;
		result_t pending[$];
		int errors;

		function new();
			pin_off = '0;
			e_gain = 16'd4096;
			t_gain = 16'd4096;
			e_off = 0;
			t_off = 0;
			x_corr = 32'h1000_0000;
			y_corr = 32'h1000_0000;
			errors = 0;
		endfunction

		function void mirror_write(logic [2:0] idx, logic [47:0] value);
			case (idx)
				REG_PIN_OFFSETS: pin_off = value;
				REG_ENERGY_GAIN: e_gain = value[15:0];
				REG_ENERGY_OFFSET: e_off = shortint'(value[15:0]);
				REG_TIME_GAIN: t_gain = value[15:0];
				REG_TIME_OFFSET: t_off = shortint'(value[15:0]);
				REG_X_CORRECTION: x_corr = value[31:0];
				REG_Y_CORRECTION: y_corr = value[31:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// Gain is Q4.12 and the result is in 1/16 units, so the product drops 8 bits.
		function longint calibrate(bit [15:0] gain, bit [15:0] raw, shortint off);
			longint v;
			v = ((longint'(gain) * longint'(raw)) >>> 8) + longint'(off);
			return clamp(v, -8388608, 8388607);
		endfunction

		// Linear position correction; the arithmetic shift floors negative products.
		function longint correct(bit [31:0] r, longint pos);
			longint g, o;
			g = longint'(r[31:16]);
			o = longint'(shortint'(r[15:0]));
			return clamp(((g * pos) >>> 12) + o, -32768, 32767);
		endfunction

		function void note_request(event_t ev);
			result_t res;
			longint e, t, sum, nx, ny, x, y, xc, yc;
			longint pc[4];
			bit [15:0] raw[4];
			int mult;
			bit [5:0] mask;
			raw[0] = ev.pin_a_raw;
			raw[1] = ev.pin_b_raw;
			raw[2] = ev.pin_c_raw;
			raw[3] = ev.pin_d_raw;
			e = calibrate(e_gain, ev.energy_raw, e_off);
			t = calibrate(t_gain, ev.time_raw, t_off);
			mult = 0;
			mask = '0;
			for (int i = 0; i < 4; i++) begin
				if (raw[i] > PinLow && raw[i] < RawLimit) begin
					mult++;
					mask[i] = 1'b1;
				end
				pc[i] = longint'(raw[i]) - longint'(pin_off[12*i +: 12]);
			end
			mask[4] = ev.energy_raw != 0;
			mask[5] = ev.time_raw != 0;
			sum = pc[0] + pc[1] + pc[2] + pc[3];
			res = '0;
			res.si_fired = ev.energy_raw > 0 && ev.energy_raw < RawLimit;
			res.energy_cal = e[23:0];
			res.time_calibrated = t[23:0];
			res.calibrated_in_window = e >= 16 && e < 65536 && t >= 160 && t < 60800;
			res.pin_multiplicity = mult[2:0];
			res.signal_mask = mask;
			// Charge division only when all four pins are in window and the sum is nonzero.
			if (mult == 4 && sum != 0) begin
				nx = longint'(PosScale) * ((pc[1] + pc[2]) - (pc[3] + pc[0]));
				ny = longint'(PosScale) * ((pc[3] + pc[2]) - (pc[0] + pc[1]));
				x = clamp(nx / sum, -32768, 32767);
				y = clamp(ny / sum, -32768, 32767);
				xc = correct(x_corr, x);
				yc = correct(y_corr, y);
				res.position_valid = 1'b1;
				res.x_position = x[15:0];
				res.y_position = y[15:0];
				res.x_corrected = xc[15:0];
				res.y_corrected = yc[15:0];
			end
			pending = {pending, res};
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("error: %s got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task field(string what, logic [23:0] got, logic [23:0] want);
			if (got !== want) report_mismatch(what, got, want);
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", got.x_position, 0);
				return;
			end
			want = pending.pop_front();
			field("si_fired", got.si_fired, want.si_fired);
			field("energy_cal", got.energy_cal, want.energy_cal);
			field("time_calibrated", got.time_calibrated, want.time_calibrated);
			field("calibrated_in_window", got.calibrated_in_window,
				want.calibrated_in_window);
			field("pin_multiplicity", got.pin_multiplicity, want.pin_multiplicity);
			field("signal_mask", got.signal_mask, want.signal_mask);
			field("position_valid", got.position_valid, want.position_valid);
			field("x_position", got.x_position, want.x_position);
			field("y_position", got.y_position, want.y_position);
			field("x_corrected", got.x_corrected, want.x_corrected);
			field("y_corrected", got.y_corrected, want.y_corrected);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;
	bit no_idle = 1'b0;
	bit long_hold = 1'b0;
	int quiet_cycles = 0;
	position_scoreboard sb = new();

	fpc_if #(.W($bits(event_t))) in_ch ();
	fpc_if #(.W($bits(result_t))) out_ch ();

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	four_pin_position_calibrator #(.RAW_WIDTH(16)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock and a single reset at the start.
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Monitor both channels and keep the watchdog.
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) sb.note_request(event_t'(in_ch.data));
		if (out_ch.valid && out_ch.ready) sb.check_result(result_t'(out_ch.data));
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result receiver with random stalls and an occasional long hold-off.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				long_hold = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task send_event(event_t ev);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= ev;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task write_reg(logic [2:0] idx, logic [47:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.mirror_write(idx, value);
		@(posedge clk);
	endtask

	// Wait until every result is back and the pipeline has drained.
	task drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	task configure(logic [47:0] offs, logic [47:0] eg, logic [47:0] eo, logic [47:0] tg,
		logic [47:0] to, logic [47:0] xc, logic [47:0] yc);
		write_reg(REG_PIN_OFFSETS, offs);
		write_reg(REG_ENERGY_GAIN, eg);
		write_reg(REG_ENERGY_OFFSET, eo);
		write_reg(REG_TIME_GAIN, tg);
		write_reg(REG_TIME_OFFSET, to);
		write_reg(REG_X_CORRECTION, xc);
		write_reg(REG_Y_CORRECTION, yc);
		// Index past the register list must be ignored.
		write_reg(RegUnused, rand48());
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function logic [15:0] pin_in_window();
		return 16'($urandom_range(PinLow + 1, RawLimit - 1));
	endfunction

	// Mostly four-pin hits with random content, the rest raw noise.
	function event_t random_event();
		event_t ev;
		ev = event_t'({$urandom(), $urandom(), $urandom()});
		if ($urandom_range(0, 3) != 0) begin
			ev.energy_raw = 16'($urandom_range(0, 4200));
			ev.time_raw = 16'($urandom_range(0, 4200));
			ev.pin_a_raw = pin_in_window();
			ev.pin_b_raw = pin_in_window();
			ev.pin_c_raw = pin_in_window();
			ev.pin_d_raw = pin_in_window();
			if ($urandom_range(0, 4) == 0) ev.pin_c_raw = 16'($urandom());
		end
		return ev;
	endfunction

	task random_phase(int count);
		repeat (count) send_event(random_event());
		drain();
	endtask

	// Main sequence: directed events, then random phases over several settings.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		// Field extremes, window edges and a normal hit under reset defaults.
		send_event('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
		send_event('{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
		send_event('{16'd4095, 16'd3799, 16'd251, 16'd251, 16'd251, 16'd251});
		send_event('{16'd4096, 16'd3800, 16'd250, 16'd4095, 16'd4096, 16'd300});
		send_event('{16'd1, 16'd10, 16'd4095, 16'd4095, 16'd4095, 16'd4095});
		send_event('{16'd1000, 16'd9, 16'd251, 16'd4095, 16'd4095, 16'd251});
		send_event('{16'd2000, 16'd2000, 16'd4095, 16'd251, 16'd251, 16'd4095});
		send_event('{16'd500, 16'd600, 16'd1000, 16'd2000, 16'd3000, 16'd400});
		drain();
		// Equal offsets and pins give a zero pin sum; negative sums and saturation.
		configure({4{12'd1000}}, 48'd65535, 48'h8000, 48'd0, 48'h7fff,
			48'hffff_ffff, 48'h0000_8000);
		send_event('{16'd100, 16'd100, 16'd1000, 16'd1000, 16'd1000, 16'd1000});
		send_event('{16'd4095, 16'd4095, 16'd999, 16'd1000, 16'd1000, 16'd1002});
		send_event('{16'd1, 16'd1, 16'd300, 16'd4000, 16'd4000, 16'd300});
		send_event('{16'd1, 16'd1, 16'd4000, 16'd300, 16'd300, 16'd4000});
		send_event('{16'd1, 16'd1, 16'd1001, 16'd999, 16'd1001, 16'd1000});
		send_event('{16'hffff, 16'hffff, 16'd251, 16'd251, 16'd251, 16'd251});
		drain();
		configure({4{12'hfff}}, 48'd0, 48'h7fff, 48'd65535, 48'h8000,
			48'h0000_7fff, 48'hffff_8000);
		send_event('{16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'd4095, 16'd4094});
		send_event('{16'd0, 16'hffff, 16'd251, 16'd4095, 16'd251, 16'd251});
		random_phase(100);
		// Back-to-back events while the receiver holds off, so the input stalls.
		configure(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(), rand48());
		no_idle = 1'b1;
		long_hold = 1'b1;
		random_phase(150);
		no_idle = 1'b0;
		for (int p = 0; p < 7; p++) begin
			configure(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
				rand48());
			no_idle = (p == 3);
			random_phase(150);
		end
		no_idle = 1'b0;
		configure(48'd0, 48'd4096, 48'd0, 48'd4096, 48'd0, 48'h1000_0000, 48'h1000_0000);
		random_phase(120);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
